// File: rtl/rifp_pkg.sv
package rifp_pkg;

    typedef enum logic [2:0] {
        KIND_SDEC = 3'd0,
        KIND_UDEC = 3'd1,
        KIND_BIN  = 3'd2,
        KIND_OCT  = 3'd3,
        KIND_HEX  = 3'd4
    } t_kind;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_NUMBER  = 2'd1;
    localparam logic [1:0] ST_NODIGIT = 2'd2;

    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] TEN        = 8'd10;

    typedef struct packed {
        logic valid;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        logic       done;
        logic       consumed;
        logic [1:0] status;
    } t_flags;

endpackage

// File: rtl/rifp_digit_decode.sv
module rifp_digit_decode (
    input  logic [2:0]      i_kind,
    input  logic [7:0]      i_char,
    output rifp_pkg::t_digit o_digit
);

    logic       w_raw_valid;
    logic [7:0] w_raw;

    always_comb begin
        w_raw_valid = 1'b1;
        w_raw       = 8'd0;
        if (i_char >= rifp_pkg::CH_ZERO && i_char <= rifp_pkg::CH_NINE) begin
            w_raw = i_char - rifp_pkg::CH_ZERO;
        end else if (i_char >= rifp_pkg::CH_LOWER_A && i_char <= rifp_pkg::CH_LOWER_F) begin
            w_raw = i_char - rifp_pkg::CH_LOWER_A + rifp_pkg::TEN;
        end else if (i_char >= rifp_pkg::CH_UPPER_A && i_char <= rifp_pkg::CH_UPPER_F) begin
            w_raw = i_char - rifp_pkg::CH_UPPER_A + rifp_pkg::TEN;
        end else begin
            w_raw_valid = 1'b0;
        end
    end

    always_comb begin
        o_digit.val = w_raw[3:0];
        case (rifp_pkg::t_kind'(i_kind))
            rifp_pkg::KIND_BIN: o_digit.valid = w_raw_valid && (w_raw < 8'd2);
            rifp_pkg::KIND_OCT: o_digit.valid = w_raw_valid && (w_raw < 8'd8);
            rifp_pkg::KIND_HEX: o_digit.valid = w_raw_valid;
            default:            o_digit.valid = w_raw_valid && (w_raw < rifp_pkg::TEN);
        endcase
    end

endmodule

// File: rtl/rifp_field_core.sv
module rifp_field_core #(
    parameter int VALUE_BITS       = 32,
    parameter int WIDTH_COUNT_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_start_req,
    input  logic [2:0]                   i_conv_kind,
    input  logic [7:0]                   i_max_width,
    input  logic [7:0]                   i_char_in,
    input  logic                         i_end_of_input,
    output rifp_pkg::t_flags             o_flags,
    output logic signed [VALUE_BITS-1:0] o_value
);

    logic [VALUE_BITS-1:0]       r_acc, n_acc;
    logic [WIDTH_COUNT_BITS-1:0] r_rem, n_rem;
    logic                        r_unl, n_unl;
    logic [2:0]                  r_mode, n_mode;
    logic                        r_neg, n_neg;
    logic                        r_seen, n_seen;
    logic                        r_active, n_active;

    logic [WIDTH_COUNT_BITS+7:0] w_maxw_ext;
    logic [WIDTH_COUNT_BITS-1:0] w_rem_dec;
    logic [2:0]                  w_mode;
    logic [VALUE_BITS-1:0]       w_acc_base;
    logic [VALUE_BITS-1:0]       w_acc_scaled;
    logic [VALUE_BITS-1:0]       w_acc_next;
    logic [VALUE_BITS-1:0]       w_result;
    logic                        w_finish;
    rifp_pkg::t_digit            w_digit;

    assign w_maxw_ext = {{WIDTH_COUNT_BITS{1'b0}}, i_max_width};

    // kind and accumulator as seen by this word, a new field starts from zero
    assign w_mode     = i_start_req ? i_conv_kind : r_mode;
    assign w_acc_base = i_start_req ? '0 : r_acc;

    rifp_digit_decode u_decode (
        .i_kind  (w_mode),
        .i_char  (i_char_in),
        .o_digit (w_digit)
    );

    // base multiply as shifts and adds
    always_comb begin
        case (rifp_pkg::t_kind'(w_mode))
            rifp_pkg::KIND_BIN: w_acc_scaled = w_acc_base << 1;
            rifp_pkg::KIND_OCT: w_acc_scaled = w_acc_base << 3;
            rifp_pkg::KIND_HEX: w_acc_scaled = w_acc_base << 4;
            default:            w_acc_scaled = (w_acc_base << 3) + (w_acc_base << 1);
        endcase
    end

    assign w_acc_next = w_acc_scaled + {{(VALUE_BITS-4){1'b0}}, w_digit.val};

    always_comb begin
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_unl    = r_unl;
        n_mode   = r_mode;
        n_neg    = r_neg;
        n_seen   = r_seen;
        n_active = r_active;
        if (i_start_req) begin
            n_acc    = '0;
            n_rem    = w_maxw_ext[WIDTH_COUNT_BITS-1:0];
            n_unl    = (i_max_width == 8'd0);
            n_mode   = i_conv_kind;
            n_neg    = 1'b0;
            n_seen   = 1'b0;
            n_active = 1'b1;
        end
        w_rem_dec = n_rem - {{(WIDTH_COUNT_BITS-1){1'b0}}, 1'b1};

        w_finish         = 1'b0;
        o_flags.consumed = 1'b0;
        if (n_active) begin
            if (i_end_of_input || (!n_unl && n_rem == '0)) begin
                w_finish = 1'b1;
            end else if (i_start_req && n_mode == rifp_pkg::KIND_SDEC
                         && i_char_in == rifp_pkg::CH_MINUS) begin
                n_neg            = 1'b1;
                o_flags.consumed = 1'b1;
                if (!n_unl) begin
                    n_rem    = w_rem_dec;
                    w_finish = (w_rem_dec == '0);
                end
            end else if (!w_digit.valid) begin
                w_finish = 1'b1;
            end else begin
                n_acc            = w_acc_next;
                n_seen           = 1'b1;
                o_flags.consumed = 1'b1;
                if (!n_unl) begin
                    n_rem    = w_rem_dec;
                    w_finish = (w_rem_dec == '0);
                end
            end
        end
        if (w_finish) begin
            n_active = 1'b0;
        end

        w_result = n_neg ? (~n_acc + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : n_acc;
        o_flags.done = w_finish;
        if (!w_finish) begin
            o_flags.status = rifp_pkg::ST_BUSY;
            o_value        = '0;
        end else if (n_seen) begin
            o_flags.status = rifp_pkg::ST_NUMBER;
            o_value        = w_result;
        end else begin
            o_flags.status = rifp_pkg::ST_NODIGIT;
            o_value        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_rem    <= '0;
            r_unl    <= 1'b0;
            r_mode   <= 3'd0;
            r_neg    <= 1'b0;
            r_seen   <= 1'b0;
            r_active <= 1'b0;
        end else if (i_en) begin
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_unl    <= n_unl;
            r_mode   <= n_mode;
            r_neg    <= n_neg;
            r_seen   <= n_seen;
            r_active <= n_active;
        end
    end

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_flags.done |=> !r_active)
        else $error("field still active after done");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active && !i_start_req |-> !o_flags.done && !o_flags.consumed)
        else $error("idle word produced a result");

    a_eoi_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end_of_input |-> !o_flags.consumed)
        else $error("end of input marked consumed");

    a_busy_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_active && !o_flags.done |-> o_flags.consumed)
        else $error("field in progress without consuming");

endmodule

// File: rtl/radix_integer_field_parser.sv
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_stall  | i_start_req i_conv_kind i_max_width i_char_in
//         |           |                    | i_end_of_input
// out     | output    | o_valid / i_stall  | o_done_res o_consumed o_value o_status
//
// one word in, one word out per cycle unless stalled; o_valid follows the input register
// the digit fold is combinational shifts and adds between input and result registers
// synchronous active-low reset clears field state and both valid flags
// a stall on the output holds the result register and a filled input register together
module radix_integer_field_parser #(
    parameter int VALUE_BITS       = 32,
    parameter int WIDTH_COUNT_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_start_req,
    input  logic [2:0]                   i_conv_kind,
    input  logic [7:0]                   i_max_width,
    input  logic [7:0]                   i_char_in,
    input  logic                         i_end_of_input,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_done_res,
    output logic                         o_consumed,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic [1:0]                   o_status
);

    logic       r_in_valid;
    logic       r_start_req;
    logic [2:0] r_conv_kind;
    logic [7:0] r_max_width;
    logic [7:0] r_char_in;
    logic       r_end_of_input;

    logic                         r_out_valid;
    rifp_pkg::t_flags             r_flags;
    logic signed [VALUE_BITS-1:0] r_value;

    logic                         w_adv;
    logic                         w_step;
    rifp_pkg::t_flags             w_flags;
    logic signed [VALUE_BITS-1:0] w_value;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_step  = r_in_valid && w_adv;
    assign o_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_start_req    <= i_start_req;
            r_conv_kind    <= i_conv_kind;
            r_max_width    <= i_max_width;
            r_char_in      <= i_char_in;
            r_end_of_input <= i_end_of_input;
        end
    end

    rifp_field_core #(
        .VALUE_BITS       (VALUE_BITS),
        .WIDTH_COUNT_BITS (WIDTH_COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_step),
        .i_start_req    (r_start_req),
        .i_conv_kind    (r_conv_kind),
        .i_max_width    (r_max_width),
        .i_char_in      (r_char_in),
        .i_end_of_input (r_end_of_input),
        .o_flags        (w_flags),
        .o_value        (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_flags <= w_flags;
            r_value <= w_value;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_done_res = r_flags.done;
    assign o_consumed = r_flags.consumed;
    assign o_status   = r_flags.status;
    assign o_value    = r_value;

endmodule

// File: verif/radix_integer_field_parser_test.sv
`timescale 1ns / 1ps

module radix_integer_field_parser_test;

    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic       start;
        logic [2:0] kind;
        logic [7:0] maxw;
        logic [7:0] ch;
        logic       eoi;
    } t_char_word;

    typedef struct packed {
        logic        done;
        logic        consumed;
        logic [31:0] value;
        logic [1:0]  status;
    } t_field_word;

    typedef struct packed {
        t_char_word  word;
        logic        fixed;
        t_field_word want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_start_req = 1'b0;
    logic [2:0] i_conv_kind = '0;
    logic [7:0] i_max_width = '0;
    logic [7:0] i_char_in = '0;
    logic i_end_of_input = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic o_done_res;
    logic o_consumed;
    logic signed [31:0] o_value;
    logic [1:0] o_status;

    radix_integer_field_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_start_req    (i_start_req),
        .i_conv_kind    (i_conv_kind),
        .i_max_width    (i_max_width),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_done_res     (o_done_res),
        .o_consumed     (o_consumed),
        .o_value        (o_value),
        .o_status       (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // field state of the predictor
    logic [31:0] acc;
    logic [7:0]  width_left;
    logic        unlimited;
    logic [2:0]  mode;
    logic        neg;
    logic        seen;
    logic        field_open;

    t_field_word pending_words[$];
    t_plan_row   plan[$];
    int          faults;
    int          counted;
    logic        calm;

    function automatic logic [4:0] radix_of(input logic [2:0] k);
        case (k)
            rifp_pkg::KIND_BIN: return 5'd2;
            rifp_pkg::KIND_OCT: return 5'd8;
            rifp_pkg::KIND_HEX: return 5'd16;
            default:            return 5'd10;
        endcase
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= rifp_pkg::CH_ZERO && c <= rifp_pkg::CH_NINE)
            return 5'(c - rifp_pkg::CH_ZERO);
        if (c >= rifp_pkg::CH_UPPER_A && c <= rifp_pkg::CH_UPPER_F)
            return 5'(c - rifp_pkg::CH_UPPER_A + 8'd10);
        if (c >= rifp_pkg::CH_LOWER_A && c <= rifp_pkg::CH_LOWER_F)
            return 5'(c - rifp_pkg::CH_LOWER_A + 8'd10);
        return 5'd16;
    endfunction

    function automatic t_field_word close_field(input logic used);
        t_field_word o;
        o = '0;
        o.done = 1'b1;
        o.consumed = used;
        if (seen) begin
            o.value = neg ? -acc : acc;
            o.status = rifp_pkg::ST_NUMBER;
        end else begin
            o.status = rifp_pkg::ST_NODIGIT;
        end
        field_open = 1'b0;
        return o;
    endfunction

    function automatic t_field_word parse_char(input t_char_word w);
        t_field_word o;
        logic [4:0]  d;
        logic [4:0]  b;
        o = '0;
        if (w.start) begin
            acc = '0;
            width_left = w.maxw;
            unlimited = (w.maxw == 8'd0);
            mode = w.kind;
            neg = 1'b0;
            seen = 1'b0;
            field_open = 1'b1;
        end
        if (!field_open) return o;
        if (w.eoi || (!unlimited && width_left == 8'd0)) return close_field(1'b0);
        if (w.start && mode == rifp_pkg::KIND_SDEC && w.ch == rifp_pkg::CH_MINUS) begin
            neg = 1'b1;
            if (!unlimited) begin
                width_left = width_left - 8'd1;
                if (width_left == 8'd0) return close_field(1'b1);
            end
            o.consumed = 1'b1;
            return o;
        end
        d = digit_value(w.ch);
        b = radix_of(mode);
        if (d >= b) return close_field(1'b0);
        acc = acc * b + d;
        seen = 1'b1;
        if (!unlimited) begin
            width_left = width_left - 8'd1;
            if (width_left == 8'd0) return close_field(1'b1);
        end
        o.consumed = 1'b1;
        return o;
    endfunction

    function automatic t_char_word mk(input logic s, input logic [2:0] k, input logic [7:0] m,
                                      input logic [7:0] c, input logic e);
        t_char_word w;
        w.start = s;
        w.kind = k;
        w.maxw = m;
        w.ch = c;
        w.eoi = e;
        return w;
    endfunction

    task automatic add_row(input t_char_word w, input logic fx, input logic dn, input logic cs,
                           input logic [31:0] v, input logic [1:0] st);
        t_plan_row r;
        r.word = w;
        r.fixed = fx;
        r.want.done = dn;
        r.want.consumed = cs;
        r.want.value = v;
        r.want.status = st;
        plan.push_back(r);
    endtask

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    task automatic send_word(input t_char_word w, input logic fx, input t_field_word typed);
        int          gap;
        t_field_word e;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_req <= w.start;
        i_conv_kind <= w.kind;
        i_max_width <= w.maxw;
        i_char_in <= w.ch;
        i_end_of_input <= w.eoi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (w.start || field_open) counted++;
        e = parse_char(w);
        pending_words.push_back(fx ? typed : e);
    endtask

    function automatic logic [7:0] digit_char(input logic [4:0] b);
        logic [4:0] d;
        d = 5'($urandom_range(0, b - 1));
        if (d < 5'd10) return rifp_pkg::CH_ZERO + 8'(d);
        if ($urandom_range(0, 1) == 0) return rifp_pkg::CH_LOWER_A + 8'(d) - 8'd10;
        return rifp_pkg::CH_UPPER_A + 8'(d) - 8'd10;
    endfunction

    // one field with random content, its end chosen at random
    task automatic send_field();
        logic [2:0] k;
        logic [7:0] m;
        logic [7:0] chars[$];
        logic       last_eoi;
        int         r;
        int         n;
        k = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        if (r < 4) m = 8'd0;
        else if (r < 8) m = 8'($urandom_range(1, 8));
        else if (r < 9) m = 8'($urandom_range(9, 20));
        else m = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
        if (k == rifp_pkg::KIND_SDEC && $urandom_range(0, 2) == 0)
            chars.push_back(rifp_pkg::CH_MINUS);
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(0, 10);
        else if (r < 95) n = $urandom_range(11, 16);
        else n = $urandom_range(17, 40);
        repeat (n) chars.push_back(digit_char(radix_of(k)));
        last_eoi = 1'b0;
        r = $urandom_range(0, 5);
        if (r == 0) begin
            last_eoi = 1'b1;
            chars.push_back(8'($urandom_range(0, 255)));
        end else if (r == 1) begin
            chars.push_back(8'($urandom_range(8'h3a, 8'h60)));
        end else if (r < 4) begin
            chars.push_back(8'($urandom_range(0, 255)));
        end
        if (chars.size() == 0) chars.push_back(8'($urandom_range(0, 255)));
        foreach (chars[i]) begin
            send_word(mk(i == 0, k, m, chars[i], last_eoi && i == chars.size() - 1),
                      1'b0, '0);
        end
    endtask

    int hold;
    int roll;
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
            hold = 0;
        end else if (hold > 0) begin
            hold = hold - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                i_stall <= 1'b0;
                hold = $urandom_range(0, 7);
            end else if (roll < 85) begin
                i_stall <= 1'b1;
                hold = $urandom_range(0, 2);
            end else if (roll < 97) begin
                i_stall <= 1'b1;
                hold = $urandom_range(3, 9);
            end else begin
                i_stall <= 1'b1;
                hold = $urandom_range(10, 29);
            end
        end
    end

    t_field_word want;
    t_field_word got;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got.done = o_done_res;
            got.consumed = o_consumed;
            got.value = o_value;
            got.status = o_status;
            if (pending_words.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected word: done %0b consumed %0b value %h status %0d",
                             got.done, got.consumed, got.value, got.status);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch: expected %0b %0b %h %0d, got %0b %0b %h %0d",
                                 want.done, want.consumed, want.value, want.status,
                                 got.done, got.consumed, got.value, got.status);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic drained;
        int   r;
        faults = 0;
        counted = 0;
        calm = 1'b0;
        drained = 1'b0;
        acc = '0;
        width_left = '0;
        unlimited = 1'b0;
        mode = '0;
        neg = 1'b0;
        seen = 1'b0;
        field_open = 1'b0;

        // idle, then a signed field with sign, ended by end of input
        add_row(mk(1'b0, rifp_pkg::KIND_SDEC, 8'd0, "5", 1'b0), 1'b1, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b1, rifp_pkg::KIND_SDEC, 8'd0, rifp_pkg::CH_MINUS, 1'b0), 1'b1, 1'b0,
                1'b1, 32'd0, rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_SDEC, 8'd0, "1", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_SDEC, 8'd0, "2", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_SDEC, 8'd0, 8'h00, 1'b1), 1'b1, 1'b1, 1'b0, -32'sd12,
                rifp_pkg::ST_NUMBER);
        // sign takes the whole width
        add_row(mk(1'b1, rifp_pkg::KIND_SDEC, 8'd1, rifp_pkg::CH_MINUS, 1'b0), 1'b1, 1'b1,
                1'b1, 32'd0, rifp_pkg::ST_NODIGIT);
        // hex in mixed case, ended by width
        add_row(mk(1'b1, rifp_pkg::KIND_HEX, 8'd8, "F", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "f", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "A", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "a", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "0", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "9", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "F", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_HEX, 8'd8, "F", 1'b0), 1'b1, 1'b1, 1'b1, 32'hffaa09ff,
                rifp_pkg::ST_NUMBER);
        // punctuation between nine and lower-case a, digit too big for the base
        add_row(mk(1'b1, rifp_pkg::KIND_HEX, 8'd0, ":", 1'b0), 1'b1, 1'b1, 1'b0, 32'd0,
                rifp_pkg::ST_NODIGIT);
        add_row(mk(1'b1, rifp_pkg::KIND_BIN, 8'd0, "2", 1'b0), 1'b1, 1'b1, 1'b0, 32'd0,
                rifp_pkg::ST_NODIGIT);
        add_row(mk(1'b1, rifp_pkg::KIND_OCT, 8'd255, "7", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_OCT, 8'd255, "8", 1'b0), 1'b1, 1'b1, 1'b0, 32'd7,
                rifp_pkg::ST_NUMBER);
        add_row(mk(1'b1, rifp_pkg::KIND_UDEC, 8'd0, "1", 1'b1), 1'b1, 1'b1, 1'b0, 32'd0,
                rifp_pkg::ST_NODIGIT);
        // unused kind, then a new start abandons the running field
        add_row(mk(1'b1, 3'd7, 8'd3, "9", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b1, rifp_pkg::KIND_BIN, 8'd2, "1", 1'b0), 1'b0, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);
        add_row(mk(1'b0, rifp_pkg::KIND_BIN, 8'd2, "1", 1'b0), 1'b1, 1'b1, 1'b1, 32'd3,
                rifp_pkg::ST_NUMBER);
        add_row(mk(1'b1, rifp_pkg::KIND_UDEC, 8'd1, "0", 1'b0), 1'b1, 1'b1, 1'b1, 32'd0,
                rifp_pkg::ST_NUMBER);
        add_row(mk(1'b1, rifp_pkg::KIND_SDEC, 8'd0, 8'hff, 1'b0), 1'b1, 1'b1, 1'b0, 32'd0,
                rifp_pkg::ST_NODIGIT);
        add_row(mk(1'b0, rifp_pkg::KIND_SDEC, 8'd0, 8'h00, 1'b0), 1'b1, 1'b0, 1'b0, 32'd0,
                rifp_pkg::ST_BUSY);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) send_word(plan[i].word, plan[i].fixed, plan[i].want);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 300 && counted < 450);
            if (!drained && counted >= 800) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                while (pending_words.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
                send_field();
            end else begin
                send_word(mk($urandom_range(0, 9) == 0, 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             $urandom_range(0, 3) == 0), 1'b0, '0);
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
